[sv/tts_pkg.sv]
package tts_pkg;

	localparam int MAX_TASKS_DEF = 16;

	localparam int FUNC_W = 2;
	localparam int ID_W   = 22;
	localparam int TIME_W = 32;
	localparam int SUM_W  = 40;

	// event kinds
	localparam logic [FUNC_W-1:0] FN_EXEC    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_ARRIVAL = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SUSP    = 2'd2;
	localparam logic [FUNC_W-1:0] FN_QUERY   = 2'd3;

	localparam logic [TIME_W-1:0] TIME_ONES = '1;
	localparam logic [SUM_W-1:0]  SUM_MAX   = '1;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   task_id;
		logic [TIME_W-1:0] time_value;
	} req_t;

	typedef struct packed {
		logic [TIME_W-1:0] max_exec_time;
		logic [TIME_W-1:0] min_inter_arrival;
		logic [TIME_W-1:0] max_self_susp;
		logic [SUM_W-1:0]  sum_self_susp;
	} stats_t;

	typedef struct packed {
		logic              is_new;
		logic              table_full;
		logic [TIME_W-1:0] max_exec_time;
		logic [TIME_W-1:0] min_inter_arrival;
		logic [TIME_W-1:0] max_self_susp;
		logic [SUM_W-1:0]  sum_self_susp;
	} rsp_t;

	// start values of a freshly claimed entry
	localparam stats_t STATS_INIT = '{
		max_exec_time:     '0,
		min_inter_arrival: TIME_ONES,
		max_self_susp:     '0,
		sum_self_susp:     '0
	};

	// request travelling along the row of cells
	typedef struct packed {
		logic   vld;
		logic   done;
		logic   is_new;
		req_t   req;
		stats_t stats;
	} token_t;

endpackage

[sv/tts_chan_if.sv]
interface tts_chan_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

[sv/task_timing_stats_table.sv]
// Per-task timing statistics table. Each request carries a task id, an event kind
// (execution time, inter-arrival time, self-suspension, or a plain query) and a
// 32-bit time value; the response gives the task's statistics after the update,
// an is_new flag when the request claimed an entry and table_full when the id of
// a request other than a query was unknown and every entry was taken. Entries
// live in a row of MAX_TASKS cells, one entry per cell, filled from cell 0 upwards
// and never released. A request walks the row one cell per clock while the row
// advances, through each cell's hand-off register in turn, and its response is
// offered from the last cell's register; requests follow each other in order, so
// a new request can be taken every cycle and the sustained rate is one per clock
// while the response is taken. When the response is not taken, the whole row holds.
module task_timing_stats_table #(
	parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tts_chan_if.sink   req,
	tts_chan_if.source rsp
);
	import tts_pkg::*;

	// token entering cell k is chain[k]; the last one is the response register
	token_t chain [MAX_TASKS+1];
	token_t last;
	logic   advance;

	// the row moves whenever the response slot is empty or being taken
	assign last    = chain[MAX_TASKS];
	assign advance = !last.vld || rsp.ready;

	assign req.ready = advance;

	// fresh request: nothing resolved yet, statistics at start values
	always_comb begin
		chain[0]        = '0;
		chain[0].vld    = req.valid;
		chain[0].req    = req.payload;
		chain[0].stats  = STATS_INIT;
	end

	for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
		tts_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1])
		);
	end

	// a request still open after the last cell found no match and no free entry;
	// a query in that case is not a full-table report
	assign rsp.valid                     = last.vld;
	assign rsp.payload.is_new            = last.is_new;
	assign rsp.payload.table_full        = !last.done && (last.req.func != FN_QUERY);
	assign rsp.payload.max_exec_time     = last.stats.max_exec_time;
	assign rsp.payload.min_inter_arrival = last.stats.min_inter_arrival;
	assign rsp.payload.max_self_susp     = last.stats.max_self_susp;
	assign rsp.payload.sum_self_susp     = last.stats.sum_self_susp;

endmodule

[sv/tts_cell.sv]
module tts_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  tts_pkg::token_t tok_in,
	output tts_pkg::token_t tok_out
);
	import tts_pkg::*;

	logic              valid_q;
	logic [ID_W-1:0]   id_q;
	stats_t            stats_q;
	logic              vld_q;
	token_t            tok_q;

	logic              open_req;
	logic              hit;
	logic              claim;
	logic              query_miss;
	stats_t            base;
	stats_t            upd;
	logic [SUM_W:0]    sum_wide;
	token_t            tok_nxt;

	assign open_req   = tok_in.vld && !tok_in.done;
	assign hit        = open_req && valid_q && (id_q == tok_in.req.task_id);
	assign claim      = open_req && !valid_q && (tok_in.req.func != FN_QUERY);
	assign query_miss = open_req && !valid_q && (tok_in.req.func == FN_QUERY);

	assign sum_wide = {1'b0, base.sum_self_susp}
		+ {{(SUM_W + 1 - TIME_W){1'b0}}, tok_in.req.time_value};

	always_comb begin
		base = claim ? STATS_INIT : stats_q;
		upd  = base;
		case (tok_in.req.func)
			FN_EXEC: begin
				if (tok_in.req.time_value > base.max_exec_time)
					upd.max_exec_time = tok_in.req.time_value;
			end
			FN_ARRIVAL: begin
				if (tok_in.req.time_value < base.min_inter_arrival)
					upd.min_inter_arrival = tok_in.req.time_value;
			end
			FN_SUSP: begin
				if (tok_in.req.time_value > base.max_self_susp)
					upd.max_self_susp = tok_in.req.time_value;
				upd.sum_self_susp = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		tok_nxt        = tok_in;
		tok_nxt.done   = tok_in.done || hit || claim || query_miss;
		tok_nxt.is_new = tok_in.is_new || claim;
		if (hit || claim)
			tok_nxt.stats = upd;
	end

	// entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance && claim) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && claim)
			id_q <= tok_in.req.task_id;
		if (advance && (hit || claim))
			stats_q <= upd;
	end

	// hand-off register to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			tok_q <= tok_nxt;
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

endmodule
